@@ rtl/hpts_pkg.sv @@
// Shared types, widths and tdata layouts for the pan/tilt slew limiter.
// Depends on nothing; every other file imports it.
package hpts_pkg;

   // angle width in bits (signed Q3.12 at sixteen bits)
   localparam int ANGLE_WIDTH = 16;

   // |diff| <= 2^W - 1, |speed| <= 2^(W-1)
   localparam int MAG_W = ANGLE_WIDTH;
   localparam int SPD_W = ANGLE_WIDTH;
   localparam int NUM_W = MAG_W + SPD_W;
   // 25 * (2^W - 1) < 2^(W+5)
   localparam int DEN_W = MAG_W + 5;
   // a limited quotient is below the axis magnitude
   localparam int QUO_W = MAG_W;

   // step factor: 0.04 taken as 1/25
   localparam int STEP_DIV = 25;

   // pipeline: lane stage, two merge stages, one divider stage per quotient bit
   localparam int SIDE_D = 2 + QUO_W;
   localparam int DEPTH  = 3 + QUO_W;

   // input item, last field in the lowest bits
   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] head_speed;
      logic signed [ANGLE_WIDTH-1:0] safe_tilt;
      logic signed [ANGLE_WIDTH-1:0] safe_pan;
      logic                          prior_tilt_off;
      logic signed [ANGLE_WIDTH-1:0] prior_tilt;
      logic                          prior_pan_off;
      logic signed [ANGLE_WIDTH-1:0] prior_pan;
      logic                          target_tilt_off;
      logic signed [ANGLE_WIDTH-1:0] target_tilt;
      logic                          target_pan_off;
      logic signed [ANGLE_WIDTH-1:0] target_pan;
   } req_type;

   // result item, last field in the lowest bits
   typedef struct packed {
      logic                          was_limited;
      logic                          out_tilt_off;
      logic signed [ANGLE_WIDTH-1:0] out_tilt;
      logic                          out_pan_off;
      logic signed [ANGLE_WIDTH-1:0] out_pan;
   } rsp_type;

   localparam int IN_BITS     = $bits(req_type);
   localparam int OUT_BITS    = $bits(rsp_type);
   localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

   // per-axis result of the lane stage
   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] start;
      logic signed [ANGLE_WIDTH-1:0] target;
      logic                          neg;
      logic                          off;
      logic [MAG_W-1:0]              mag;
   } lane_type;

   // merged values handed to the dividers
   typedef struct packed {
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] num_pan;
      logic [NUM_W-1:0] num_tilt;
      logic             lim;
   } merge_type;

endpackage

@@ rtl/hpts_lane.sv @@
// One axis lane: start angle selection, signed difference and its magnitude.
// Depends on hpts_pkg for widths and lane_type.
module hpts_lane
   import hpts_pkg::*;
(
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [ANGLE_WIDTH-1:0] target,
   input  logic                          target_off,
   input  logic signed [ANGLE_WIDTH-1:0] prior,
   input  logic                          prior_off,
   input  logic signed [ANGLE_WIDTH-1:0] safe,
   output lane_type                      lane_ff
);

   logic signed [ANGLE_WIDTH-1:0] start;
   logic signed [ANGLE_WIDTH:0]   diff;
   logic signed [ANGLE_WIDTH:0]   diff_neg;
   lane_type                      lane_in;

   // start from the prior command, or the safe angle when it was off
   always_comb begin
      start    = prior_off ? safe : prior;
      diff     = {target[ANGLE_WIDTH-1], target} - {start[ANGLE_WIDTH-1], start};
      diff_neg = -diff;
      lane_in.start  = start;
      lane_in.target = target;
      lane_in.off    = target_off;
      if (target_off) begin
         lane_in.neg = 1'b0;
         lane_in.mag = '0;
      end else begin
         lane_in.neg = diff[ANGLE_WIDTH];
         lane_in.mag = diff[ANGLE_WIDTH] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
      end
   end

   // lane register
   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

endmodule

@@ rtl/hpts_merge.sv @@
// Merge stage: larger axis magnitude, step test and divider operands.
// Depends on hpts_pkg; two register stages.
module hpts_merge
   import hpts_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [MAG_W-1:0] mag_pan,
   input  logic [MAG_W-1:0] mag_tilt,
   input  logic [SPD_W-1:0] spd,
   output merge_type        merge_ff
);

   logic [MAG_W-1:0] dmax_ff;
   logic [NUM_W-1:0] num_pan_ff;
   logic [NUM_W-1:0] num_tilt_ff;
   logic [SPD_W-1:0] spd_ff;
   logic [DEN_W-1:0] den_in;
   merge_type        merge_in;

   // first stage: larger magnitude and the two numerator products
   always_ff @(posedge clock) begin
      if (en) begin
         dmax_ff     <= (mag_pan > mag_tilt) ? mag_pan : mag_tilt;
         num_pan_ff  <= NUM_W'(mag_pan) * NUM_W'(spd);
         num_tilt_ff <= NUM_W'(mag_tilt) * NUM_W'(spd);
         spd_ff      <= spd;
      end
   end

   // second stage: denominator 25 * dmax as shift and add, then the limit test
   always_comb begin
      den_in = (DEN_W'(dmax_ff) << 4) + (DEN_W'(dmax_ff) << 3) + DEN_W'(dmax_ff);
      merge_in.den      = den_in;
      merge_in.num_pan  = num_pan_ff;
      merge_in.num_tilt = num_tilt_ff;
      merge_in.lim      = den_in > DEN_W'(spd_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         merge_ff <= merge_in;
      end
   end

endmodule

@@ rtl/hpts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on hpts_pkg; the quotient is valid when it is known to fit QUO_W bits.
module hpts_div
   import hpts_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];

   genvar s;
   generate
      for (s = 0; s < QUO_W; s++) begin : g_stage
         logic [DEN_W-1:0] rem_src;
         logic [QUO_W-1:0] low_src;
         logic [QUO_W-1:0] quo_src;
         logic [DEN_W-1:0] den_src;
         logic [DEN_W:0]   trial;
         logic [DEN_W:0]   diff;
         logic             ge;

         // operands come from the inputs or the previous stage
         if (s == 0) begin : g_first
            always_comb begin
               rem_src = DEN_W'(num[NUM_W-1:QUO_W]);
               low_src = num[QUO_W-1:0];
               quo_src = '0;
               den_src = den;
            end
         end else begin : g_next
            always_comb begin
               rem_src = rem_ff[s-1];
               low_src = low_ff[s-1];
               quo_src = quo_ff[s-1];
               den_src = den_ff[s-1];
            end
         end

         // one shift, compare and subtract
         always_comb begin
            trial = {rem_src, low_src[QUO_W-1]};
            diff  = trial - {1'b0, den_src};
            ge    = trial >= {1'b0, den_src};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               low_ff[s] <= {low_src[QUO_W-2:0], 1'b0};
               quo_ff[s] <= {quo_src[QUO_W-2:0], ge};
               den_ff[s] <= den_src;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QUO_W-1];

endmodule

@@ rtl/head_pan_tilt_slew_limiter.sv @@
// Two-axis head slew limiter: lanes, merge, per-axis dividers, output skid.
// Throughput one item per cycle while the skid stage is empty; the divider pipeline,
// one quotient bit per stage, sets the latency. Synchronous reset clears the valid
// bits of the pipeline, the output register and the skid stage; payload registers
// are not reset.
module head_pan_tilt_slew_limiter
   import hpts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // fields from bit 0: target_pan, target_pan_off, target_tilt, target_tilt_off,
   // prior_pan, prior_pan_off, prior_tilt, prior_tilt_off, safe_pan, safe_tilt,
   // head_speed, zero fill
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fields from bit 0: out_pan, out_pan_off, out_tilt, out_tilt_off,
   // was_limited, zero fill
   output logic [OUT_TDATA_W-1:0] rsp_tdata
);

   req_type          req;
   logic             en;
   logic [SPD_W-1:0] spd_in;
   logic [SPD_W-1:0] spd_ff;
   lane_type         lane_pan;
   lane_type         lane_tilt;
   merge_type        merge;
   logic [QUO_W-1:0] quo_pan;
   logic [QUO_W-1:0] quo_tilt;
   logic             v_ff [DEPTH];
   lane_type         side_pan_ff [SIDE_D];
   lane_type         side_tilt_ff [SIDE_D];
   logic             lim_ff [QUO_W];
   rsp_type          res;
   rsp_type          out_ff;
   rsp_type          skid_ff;
   logic             out_valid_ff;
   logic             skid_v_ff;
   logic             take;
   lane_type         sp;
   lane_type         st;
   logic             lim;

   assign req = req_type'(req_tdata[IN_BITS-1:0]);

   // the whole pipe moves while the skid stage is empty
   assign en         = !skid_v_ff;
   assign req_tready = !skid_v_ff;

   // speed magnitude, sign ignored
   assign spd_in = req.head_speed[ANGLE_WIDTH-1] ? SPD_W'(-req.head_speed)
                                                 : SPD_W'(req.head_speed);

   always_ff @(posedge clock) begin
      if (en) begin
         spd_ff <= spd_in;
      end
   end

   // axis lanes
   hpts_lane u_lane_pan (
      .clock      (clock),
      .en         (en),
      .target     (req.target_pan),
      .target_off (req.target_pan_off),
      .prior      (req.prior_pan),
      .prior_off  (req.prior_pan_off),
      .safe       (req.safe_pan),
      .lane_ff    (lane_pan)
   );

   hpts_lane u_lane_tilt (
      .clock      (clock),
      .en         (en),
      .target     (req.target_tilt),
      .target_off (req.target_tilt_off),
      .prior      (req.prior_tilt),
      .prior_off  (req.prior_tilt_off),
      .safe       (req.safe_tilt),
      .lane_ff    (lane_tilt)
   );

   // merge of the two lanes
   hpts_merge u_merge (
      .clock    (clock),
      .en       (en),
      .mag_pan  (lane_pan.mag),
      .mag_tilt (lane_tilt.mag),
      .spd      (spd_ff),
      .merge_ff (merge)
   );

   // scaled magnitudes, one divider per axis
   hpts_div u_div_pan (
      .clock (clock),
      .en    (en),
      .num   (merge.num_pan),
      .den   (merge.den),
      .quo   (quo_pan)
   );

   hpts_div u_div_tilt (
      .clock (clock),
      .en    (en),
      .num   (merge.num_tilt),
      .den   (merge.den),
      .quo   (quo_tilt)
   );

   // valid bits of the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int i = 1; i < DEPTH; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // axis sideband and limit flag follow the item down the pipe
   always_ff @(posedge clock) begin
      if (en) begin
         side_pan_ff[0]  <= lane_pan;
         side_tilt_ff[0] <= lane_tilt;
         for (int i = 1; i < SIDE_D; i++) begin
            side_pan_ff[i]  <= side_pan_ff[i-1];
            side_tilt_ff[i] <= side_tilt_ff[i-1];
         end
         lim_ff[0] <= merge.lim;
         for (int i = 1; i < QUO_W; i++) begin
            lim_ff[i] <= lim_ff[i-1];
         end
      end
   end

   // final angles: zero when off, target when free, start plus signed scaled step when limited
   always_comb begin
      sp  = side_pan_ff[SIDE_D-1];
      st  = side_tilt_ff[SIDE_D-1];
      lim = lim_ff[QUO_W-1];
      res.was_limited  = lim;
      res.out_pan_off  = sp.off;
      res.out_tilt_off = st.off;
      if (sp.off) begin
         res.out_pan = '0;
      end else if (lim) begin
         res.out_pan = sp.neg ? sp.start - $signed(ANGLE_WIDTH'(quo_pan))
                              : sp.start + $signed(ANGLE_WIDTH'(quo_pan));
      end else begin
         res.out_pan = sp.target;
      end
      if (st.off) begin
         res.out_tilt = '0;
      end else if (lim) begin
         res.out_tilt = st.neg ? st.start - $signed(ANGLE_WIDTH'(quo_tilt))
                               : st.start + $signed(ANGLE_WIDTH'(quo_tilt));
      end else begin
         res.out_tilt = st.target;
      end
   end

   // output register with skid stage
   assign take = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (v_ff[DEPTH-1]) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (v_ff[DEPTH-1]) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_TDATA_W'(out_ff);

   // skid stage holds an item only behind a waiting output item
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   // a stalled output with a result arriving fills the skid stage
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (!skid_v_ff && out_valid_ff && !rsp_tready && v_ff[DEPTH-1]) |=> skid_v_ff)
      else $error("result lost while output stalled");

   // off axes read as zero, and both off never limits
   a_off_axes: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((!out_ff.out_pan_off || out_ff.out_pan == '0) &&
                        (!out_ff.out_tilt_off || out_ff.out_tilt == '0) &&
                        !(out_ff.was_limited && out_ff.out_pan_off && out_ff.out_tilt_off)))
      else $error("off axis result inconsistent");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the pan/tilt slew limiter: directed and random frames,
// random stalls on both streams, results checked in order against a local predictor.
// Depends on hpts_pkg and head_pan_tilt_slew_limiter.
module testbench;
   import hpts_pkg::*;

   // expected frame results and the checks against them
   class slew_scoreboard;
      rsp_type     expected_moves[$];
      int unsigned fail_count;
      int unsigned seen;

      function new();
         fail_count = 0;
         seen = 0;
      endfunction

      // truncating scale of one axis difference
      function longint scale_axis(longint diff, longint spd, longint den);
         longint q;
         q = ((diff < 0 ? -diff : diff) * spd) / den;
         return diff < 0 ? -q : q;
      endfunction

      // next pan/tilt command for one frame
      function rsp_type next_angles(req_type r);
         rsp_type res;
         longint  start_p, start_t, dp, dt, mp, mt, dmax, spd;
         bit      lim;
         start_p = r.prior_pan_off  ? longint'(r.safe_pan)  : longint'(r.prior_pan);
         start_t = r.prior_tilt_off ? longint'(r.safe_tilt) : longint'(r.prior_tilt);
         spd = longint'(r.head_speed);
         if (spd < 0) spd = -spd;
         dp = r.target_pan_off  ? 0 : longint'(r.target_pan)  - start_p;
         dt = r.target_tilt_off ? 0 : longint'(r.target_tilt) - start_t;
         mp = dp < 0 ? -dp : dp;
         mt = dt < 0 ? -dt : dt;
         dmax = mp > mt ? mp : mt;
         // step per frame is speed / 25
         lim = (dmax * STEP_DIV) > spd;
         if (lim) begin
            dp = scale_axis(dp, spd, dmax * STEP_DIV);
            dt = scale_axis(dt, spd, dmax * STEP_DIV);
         end
         res.out_pan      = r.target_pan_off  ? '0 : ANGLE_WIDTH'(start_p + dp);
         res.out_pan_off  = r.target_pan_off;
         res.out_tilt     = r.target_tilt_off ? '0 : ANGLE_WIDTH'(start_t + dt);
         res.out_tilt_off = r.target_tilt_off;
         res.was_limited  = lim;
         return res;
      endfunction

      function void note_request(req_type r);
         expected_moves.push_back(next_angles(r));
      endfunction

      function int pending();
         return expected_moves.size();
      endfunction

      task report(string msg);
         fail_count++;
         $display("mismatch: %s", msg);
      endtask

      // one result item against the oldest expectation
      task check_response(logic [OUT_TDATA_W-1:0] d);
         rsp_type got, want;
         got = rsp_type'(d[OUT_BITS-1:0]);
         seen++;
         if (expected_moves.size() == 0) begin
            report($sformatf("unexpected result item %h", d));
         end else begin
            want = expected_moves.pop_front();
            if (got.out_pan !== want.out_pan)
               report($sformatf("out_pan %0d, want %0d", got.out_pan, want.out_pan));
            if (got.out_pan_off !== want.out_pan_off)
               report($sformatf("out_pan_off %b, want %b", got.out_pan_off, want.out_pan_off));
            if (got.out_tilt !== want.out_tilt)
               report($sformatf("out_tilt %0d, want %0d", got.out_tilt, want.out_tilt));
            if (got.out_tilt_off !== want.out_tilt_off)
               report($sformatf("out_tilt_off %b, want %b", got.out_tilt_off, want.out_tilt_off));
            if (got.was_limited !== want.was_limited)
               report($sformatf("was_limited %b, want %b", got.was_limited, want.was_limited));
            if (d[OUT_TDATA_W-1:OUT_BITS] !== '0)
               report($sformatf("fill bits %b not zero", d[OUT_TDATA_W-1:OUT_BITS]));
         end
      endtask

      task flush_check();
         while (expected_moves.size() != 0) begin
            void'(expected_moves.pop_front());
            report("expected result item never arrived");
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // fields from bit 0: target_pan, target_pan_off, target_tilt, target_tilt_off,
   // prior_pan, prior_pan_off, prior_tilt, prior_tilt_off, safe_pan, safe_tilt,
   // head_speed, zero fill
   logic [IN_TDATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // fields from bit 0: out_pan, out_pan_off, out_tilt, out_tilt_off,
   // was_limited, zero fill
   logic [OUT_TDATA_W-1:0] rsp_tdata;

   slew_scoreboard moves;

   head_pan_tilt_slew_limiter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // build one frame from plain integers
   function automatic req_type frame(int tp, bit tpo, int tt, bit tto, int pp, bit ppo,
                                     int pt, bit pto, int sp, int st, int spd);
      req_type r;
      r.target_pan      = tp[ANGLE_WIDTH-1:0];
      r.target_pan_off  = tpo;
      r.target_tilt     = tt[ANGLE_WIDTH-1:0];
      r.target_tilt_off = tto;
      r.prior_pan       = pp[ANGLE_WIDTH-1:0];
      r.prior_pan_off   = ppo;
      r.prior_tilt      = pt[ANGLE_WIDTH-1:0];
      r.prior_tilt_off  = pto;
      r.safe_pan        = sp[ANGLE_WIDTH-1:0];
      r.safe_tilt       = st[ANGLE_WIDTH-1:0];
      r.head_speed      = spd[ANGLE_WIDTH-1:0];
      return r;
   endfunction

   // angle biased towards extremes and small values
   function automatic int rand_angle();
      case ($urandom_range(3))
         0, 1: return int'($urandom_range(65535)) - 32768;
         2: begin
            case ($urandom_range(3))
               0: return -32768;
               1: return 32767;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(64)) - 32;
      endcase
   endfunction

   function automatic int rand_speed();
      case ($urandom_range(4))
         0, 1: return int'($urandom_range(65535)) - 32768;
         2: return int'($urandom_range(400)) - 200;
         3: return int'($urandom_range(40000));
         default: begin
            case ($urandom_range(4))
               0: return 0;
               1: return -32768;
               2: return 32767;
               3: return 1;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   // random frame; targets mostly near the start so both limited and free moves occur
   function automatic req_type rand_request();
      req_type r;
      int      start_p, start_t;
      r = frame(rand_angle(), $urandom_range(99) < 20, rand_angle(), $urandom_range(99) < 20,
                rand_angle(), $urandom_range(99) < 20, rand_angle(), $urandom_range(99) < 20,
                rand_angle(), rand_angle(), rand_speed());
      start_p = r.prior_pan_off  ? int'(r.safe_pan)  : int'(r.prior_pan);
      start_t = r.prior_tilt_off ? int'(r.safe_tilt) : int'(r.prior_tilt);
      if ($urandom_range(99) < 60) begin
         r.target_pan  = ANGLE_WIDTH'(start_p + int'($urandom_range(4000)) - 2000);
         r.target_tilt = ANGLE_WIDTH'(start_t + int'($urandom_range(4000)) - 2000);
      end
      return r;
   endfunction

   // offer one item, with random gaps unless calm; returns at the next falling edge
   task automatic send_item(req_type r, bit calm);
      while (!calm && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, r};
      do @(posedge clock); while (!req_tready);
      moves.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (moves.pending() != 0);
   endtask

   // result side: random stalls, one long hold-off, one calm stretch
   initial begin
      int unsigned hold_left;
      bit          held_once;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(negedge clock);
         if (moves != null && !held_once && moves.seen >= 150) begin
            held_once = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (moves != null && moves.seen >= 300 && moves.seen < 450) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 24);
         end
      end
   end

   // result sampling
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) moves.check_response(rsp_tdata);
   end

   // stimulus and end of run
   initial begin
      moves = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // everything zero
      send_item(frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      // full-range moves at top speed, both directions
      send_item(frame(32767, 0, -32768, 0, -32768, 0, 32767, 0, 0, 0, 32767), 1'b0);
      send_item(frame(-32768, 0, 32767, 0, 32767, 0, -32768, 0, 0, 0, -32768), 1'b0);
      // one axis off, then the other, then both
      send_item(frame(1000, 1, 2000, 0, 5, 0, -7, 0, 0, 0, 300), 1'b0);
      send_item(frame(1000, 0, 2000, 1, 5, 0, -7, 0, 0, 0, 300), 1'b0);
      send_item(frame(1000, 1, 2000, 1, 5, 0, -7, 0, 0, 0, 300), 1'b0);
      // zero speed with a difference: stays at the start
      send_item(frame(4000, 0, -4000, 0, 100, 0, -100, 0, 0, 0, 0), 1'b0);
      // prior off falls back to the safe angles
      send_item(frame(500, 0, -500, 0, 9999, 1, -9999, 1, 480, -470, 25000), 1'b0);
      send_item(frame(32767, 0, -32768, 0, 0, 1, 0, 1, -32768, 32767, 32767), 1'b0);
      // small free move at top speed
      send_item(frame(10, 0, -10, 0, 0, 0, 0, 0, 0, 0, 32767), 1'b0);
      // step exactly equal to the difference: not limited
      send_item(frame(100, 0, 50, 0, 0, 0, 0, 0, 0, 0, 2500), 1'b0);
      // step one below: limited, truncation toward zero on both signs
      send_item(frame(100, 0, -50, 0, 0, 0, 0, 0, 0, 0, 2499), 1'b0);
      send_item(frame(-100, 0, 33, 0, 0, 0, 0, 0, 0, 0, 2499), 1'b0);
      // speed of minus one
      send_item(frame(-1, 0, 1, 0, 0, 0, 0, 0, 0, 0, -1), 1'b0);
      // all field bits high, then alternating patterns
      send_item(frame(-1, 1, -1, 1, -1, 1, -1, 1, -1, -1, -1), 1'b0);
      send_item(frame(21845, 0, -21846, 0, -21846, 1, 21845, 0, 21845, -21846, 21845), 1'b0);
      send_item(frame(-21846, 0, 21845, 1, 21845, 0, -21846, 1, -21846, 21845, -21846), 1'b0);

      // random frames, with a calm stretch and a full drain partway through
      for (int i = 0; i < 800; i++) begin
         if (i == 500) drain();
         send_item(rand_request(), i >= 300 && i < 450);
      end

      drain();
      repeat (4 * DEPTH) @(negedge clock);
      moves.flush_check();
      if (moves.fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1600000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
